### design/apt_pkg.sv
// shared types and constants of the altitude pid thrust controller
package apt_pkg;

    // fixed field widths
    localparam int CFG_BITS     = 31;
    localparam int IN_BITS      = 32;
    localparam int TILT_BITS    = 18;
    localparam int OUT_BITS     = 32;
    localparam int CFG_IDX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_POS_GAIN      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VEL_GAIN      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTEGRAL_GAIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VEHICLE_MASS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ASCENT_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP     = 3'd5;

    // register reset values
    localparam logic [CFG_BITS-1:0] RST_POS_GAIN      = 31'd0;
    localparam logic [CFG_BITS-1:0] RST_VEL_GAIN      = 31'd0;
    localparam logic [CFG_BITS-1:0] RST_INTEGRAL_GAIN = 31'd0;
    localparam logic [CFG_BITS-1:0] RST_VEHICLE_MASS  = 31'd65536;
    localparam logic [CFG_BITS-1:0] RST_ASCENT_LIMIT  = 31'd6553600;
    localparam logic [CFG_BITS-1:0] RST_TIME_STEP     = 31'd655;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_I,
        ST_MUL_G,
        ST_DIV_C,
        ST_MUL_T,
        ST_OUT
    } state_t;

endpackage

### design/altitude_pid_thrust_top.sv
// altitude pid thrust controller: sequencer around one shared multiplier and one divider
//
// Takes one word at a time (s_ready is high only while the sequencer is idle) and
// returns one thrust word per input word. All products run on a single 31 x 16 bit
// multiplier, one 16-bit digit per cycle, and both quotients on a shared restoring
// divider that retires two quotient bits per cycle. The tilt division is skipped when
// the tilt cosine is zero. The first item after reset or after a write to ascent_limit
// or time_step also recomputes the climb limit on the divider. A finished result waits
// in an output register, so the next word can be accepted before m_ready comes back.
module altitude_pid_thrust_top import apt_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [CFG_BITS-1:0]            cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [IN_BITS-1:0]      s_target_height,
    input  logic signed [IN_BITS-1:0]      s_target_climb,
    input  logic signed [IN_BITS-1:0]      s_height_now,
    input  logic signed [IN_BITS-1:0]      s_climb_now,
    input  logic signed [IN_BITS-1:0]      s_accel_feedforward,
    input  logic signed [TILT_BITS-1:0]    s_tilt_cosine,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [OUT_BITS-1:0]     m_thrust
);

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int MAXW   = (W > CFG_BITS) ? W : CFG_BITS;
    localparam int NW     = MAXW + F;
    localparam int NWP    = ((NW + 1) / 2) * 2;
    localparam int HALF   = NWP / 2;
    localparam int DIG    = 16;
    localparam int ND     = (W + DIG - 1) / DIG;
    localparam int BW     = ND * DIG;
    localparam int PW     = CFG_BITS + BW;
    localparam int SW     = ((PW - F) > NWP) ? (PW - F) : NWP;
    localparam int CNT_MAX = ((HALF > ND) ? HALF : ND) + 1;
    localparam int CW     = $clog2(CNT_MAX + 1);

    localparam logic signed [63:0] WMAX_L = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] WMIN_L = -WMAX_L - 64'sd1;
    localparam logic signed [63:0] OMAX_L = 64'sd2147483647;
    localparam logic signed [63:0] OMIN_L = -64'sd2147483648;
    localparam logic signed [63:0] GRAV_L = ((64'sd981 <<< F) + 64'sd50) / 64'sd100;
    localparam logic signed [W-1:0] WMAX_W = W'(WMAX_L);
    localparam logic signed [W-1:0] WMIN_W = W'(WMIN_L);
    localparam logic [SW-1:0]       WMAX_M = SW'(WMAX_L);
    localparam logic [SW-1:0]       WMIN_M = WMAX_M + SW'(1);

    function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
        logic signed [W-1:0] r;
        if (v > WMAX_L) begin
            r = WMAX_W;
        end else if (v < WMIN_L) begin
            r = WMIN_W;
        end else begin
            r = W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [63:0] v);
        logic signed [OUT_BITS-1:0] r;
        if (v > OMAX_L) begin
            r = OUT_BITS'(OMAX_L);
        end else if (v < OMIN_L) begin
            r = OUT_BITS'(OMIN_L);
        end else begin
            r = OUT_BITS'(v);
        end
        return r;
    endfunction

    // signed result from a magnitude, saturated to the word
    function automatic logic signed [W-1:0] sat_mag(input logic [SW-1:0] m, input logic neg);
        logic signed [W-1:0] r;
        if (neg) begin
            r = (m > WMIN_M) ? WMIN_W : W'(SW'(0) - m);
        end else begin
            r = (m > WMAX_M) ? WMAX_W : W'(m);
        end
        return r;
    endfunction

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] x);
        logic [W-1:0] r;
        r = x[W-1] ? (~x + W'(1)) : x;
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [CFG_BITS-1:0] pos_gain_reg, pos_gain_next;
    logic [CFG_BITS-1:0] vel_gain_reg, vel_gain_next;
    logic [CFG_BITS-1:0] integral_gain_reg, integral_gain_next;
    logic [CFG_BITS-1:0] vehicle_mass_reg, vehicle_mass_next;
    logic [CFG_BITS-1:0] ascent_limit_reg, ascent_limit_next;
    logic [CFG_BITS-1:0] time_step_reg, time_step_next;

    logic                 lim_ok_reg, lim_ok_next;
    logic signed [W-1:0]  lim_reg, lim_next;
    logic signed [W-1:0]  ei_reg, ei_next;
    logic signed [W-1:0]  ep_reg, ep_next;
    logic signed [W-1:0]  ev_reg, ev_next;
    logic signed [W-1:0]  ff_reg, ff_next;
    logic signed [TILT_BITS-1:0] tilt_reg, tilt_next;
    logic signed [W-1:0]  p_reg, p_next;
    logic signed [W-1:0]  d_reg, d_next;
    logic signed [W-1:0]  num_reg, num_next;
    logic signed [W-1:0]  c_reg, c_next;
    logic signed [W-1:0]  fm_reg, fm_next;

    logic [CFG_BITS-1:0]  mul_a_reg, mul_a_next;
    logic [BW-1:0]        mul_b_reg, mul_b_next;
    logic                 mul_neg_reg, mul_neg_next;
    logic [PW-1:0]        acc_reg, acc_next;

    logic [CFG_BITS-1:0]  div_d_reg, div_d_next;
    logic [CFG_BITS-1:0]  rem_reg, rem_next;
    logic [NWP-1:0]       quo_reg, quo_next;
    logic                 div_neg_reg, div_neg_next;

    logic                 m_valid_reg, m_valid_next;
    logic signed [OUT_BITS-1:0] m_thrust_reg, m_thrust_next;

    logic signed [W-1:0]  th_w, tc_w, hn_w, cn_w;
    logic                 accept, out_free;
    logic                 mul_last, div_last, tilt_zero;
    logic [CFG_BITS-1:0]  op_a;
    logic signed [W-1:0]  op_b;
    logic [CFG_BITS+DIG-1:0] pp;
    logic [PW-1:0]        acc_step;
    logic [CFG_BITS-1:0]  rem_step;
    logic [NWP-1:0]       quo_step;
    logic signed [W-1:0]  mul_res, div_res, u_sum, t_w;
    logic [TILT_BITS-1:0] tilt_mag;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_thrust = m_thrust_reg;

    assign th_w = sat_w(64'(s_target_height));
    assign tc_w = sat_w(64'(s_target_climb));
    assign hn_w = sat_w(64'(s_height_now));
    assign cn_w = sat_w(64'(s_climb_now));

    assign mul_last  = (cnt_reg == CW'(ND + 1));
    assign div_last  = (cnt_reg == CW'(HALF + 1));
    assign tilt_zero = (tilt_reg == '0);
    assign tilt_mag  = tilt_reg[TILT_BITS-1] ? (~tilt_reg + TILT_BITS'(1)) : tilt_reg;

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            ST_MUL_P: begin
                op_a = pos_gain_reg;
                op_b = ep_reg;
            end
            ST_MUL_D: begin
                op_a = vel_gain_reg;
                op_b = ev_reg;
            end
            ST_MUL_I: begin
                op_a = time_step_reg;
                op_b = ep_reg;
            end
            ST_MUL_G: begin
                op_a = integral_gain_reg;
                op_b = ei_reg;
            end
            ST_MUL_T: begin
                op_a = vehicle_mass_reg;
                op_b = c_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // one digit of the multiplier, most significant first
    always_comb begin
        pp       = mul_a_reg * mul_b_reg[BW-1 -: DIG];
        acc_step = (acc_reg << DIG) + PW'(pp);
    end

    // two restoring division steps
    always_comb begin : div_step
        logic [CFG_BITS:0] r2;
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int k = 0; k < 2; k++) begin
            r2 = {rem_step, quo_step[NWP-1]};
            if (r2 >= {1'b0, div_d_reg}) begin
                rem_step = CFG_BITS'(r2 - {1'b0, div_d_reg});
                quo_step = {quo_step[NWP-2:0], 1'b1};
            end else begin
                rem_step = r2[CFG_BITS-1:0];
                quo_step = {quo_step[NWP-2:0], 1'b0};
            end
        end
    end

    assign mul_res = sat_mag(SW'(acc_reg >> F), mul_neg_reg);
    assign div_res = sat_mag(SW'(quo_reg), div_neg_reg);
    assign u_sum   = sat_w(64'(p_reg) + 64'(d_reg) + 64'(mul_res) + 64'(ff_reg));
    assign t_w     = sat_w(-64'(fm_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // a limit register written on this edge forces a fresh limit
                    state_next = lim_ok_next ? ST_MUL_P : ST_LIM;
                end
            end
            ST_LIM: begin
                if (div_last) begin
                    state_next = ST_MUL_P;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_MUL_P, ST_MUL_D, ST_MUL_I, ST_MUL_G, ST_MUL_T: begin
                if (mul_last) begin
                    case (state_reg)
                        ST_MUL_P: state_next = ST_MUL_D;
                        ST_MUL_D: state_next = ST_MUL_I;
                        ST_MUL_I: state_next = ST_MUL_G;
                        ST_MUL_G: state_next = ST_DIV_C;
                        default:  state_next = ST_OUT;
                    endcase
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DIV_C: begin
                if ((cnt_reg == '0) && tilt_zero) begin
                    state_next = ST_MUL_T;
                end else if (div_last) begin
                    state_next = ST_MUL_T;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        pos_gain_next      = pos_gain_reg;
        vel_gain_next      = vel_gain_reg;
        integral_gain_next = integral_gain_reg;
        vehicle_mass_next  = vehicle_mass_reg;
        ascent_limit_next  = ascent_limit_reg;
        time_step_next     = time_step_reg;
        lim_ok_next        = lim_ok_reg;
        lim_next           = lim_reg;
        ei_next            = ei_reg;
        ep_next            = ep_reg;
        ev_next            = ev_reg;
        ff_next            = ff_reg;
        tilt_next          = tilt_reg;
        p_next             = p_reg;
        d_next             = d_reg;
        num_next           = num_reg;
        c_next             = c_reg;
        fm_next            = fm_reg;
        mul_a_next         = mul_a_reg;
        mul_b_next         = mul_b_reg;
        mul_neg_next       = mul_neg_reg;
        acc_next           = acc_reg;
        div_d_next         = div_d_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        div_neg_next       = div_neg_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_thrust_next      = m_thrust_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_POS_GAIN:      pos_gain_next = cfg_wdata;
                REG_VEL_GAIN:      vel_gain_next = cfg_wdata;
                REG_INTEGRAL_GAIN: integral_gain_next = cfg_wdata;
                REG_VEHICLE_MASS:  vehicle_mass_next = cfg_wdata;
                REG_ASCENT_LIMIT: begin
                    ascent_limit_next = cfg_wdata;
                    lim_ok_next       = 1'b0;
                end
                REG_TIME_STEP: begin
                    time_step_next = cfg_wdata;
                    lim_ok_next    = 1'b0;
                end
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ep_next   = sat_w(64'(th_w) - 64'(hn_w));
                    ev_next   = sat_w(64'(tc_w) - 64'(cn_w));
                    ff_next   = sat_w(64'(s_accel_feedforward));
                    tilt_next = s_tilt_cosine;
                end
            end
            ST_LIM, ST_DIV_C: begin
                if (cnt_reg == '0) begin
                    rem_next = '0;
                    if (state_reg == ST_LIM) begin
                        quo_next     = NWP'(ascent_limit_reg) << F;
                        div_d_next   = (time_step_reg == '0) ? CFG_BITS'(1) : time_step_reg;
                        div_neg_next = 1'b0;
                    end else begin
                        quo_next     = NWP'(mag_w(num_reg)) << F;
                        div_d_next   = CFG_BITS'(tilt_mag);
                        div_neg_next = num_reg[W-1] ^ tilt_reg[TILT_BITS-1];
                        // vertical tilt: straight to the bound on the side of the numerator
                        if (tilt_zero) begin
                            c_next = num_reg[W-1] ? -lim_reg : lim_reg;
                        end
                    end
                end else if (div_last) begin
                    if (state_reg == ST_LIM) begin
                        lim_next    = div_res;
                        lim_ok_next = 1'b1;
                    end else if (div_res > lim_reg) begin
                        c_next = lim_reg;
                    end else if (div_res < -lim_reg) begin
                        c_next = -lim_reg;
                    end else begin
                        c_next = div_res;
                    end
                end else begin
                    rem_next = rem_step;
                    quo_next = quo_step;
                end
            end
            ST_MUL_P, ST_MUL_D, ST_MUL_I, ST_MUL_G, ST_MUL_T: begin
                if (cnt_reg == '0) begin
                    mul_a_next   = op_a;
                    mul_b_next   = BW'(mag_w(op_b));
                    mul_neg_next = op_b[W-1];
                    acc_next     = '0;
                end else if (mul_last) begin
                    case (state_reg)
                        ST_MUL_P: p_next = mul_res;
                        ST_MUL_D: d_next = mul_res;
                        ST_MUL_I: ei_next = sat_w(64'(ei_reg) + 64'(mul_res));
                        ST_MUL_G: num_next = sat_w(64'(u_sum) - GRAV_L);
                        default:  fm_next = mul_res;
                    endcase
                end else begin
                    acc_next   = acc_step;
                    mul_b_next = mul_b_reg << DIG;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_thrust_next = sat_out(64'(t_w));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            pos_gain_reg      <= RST_POS_GAIN;
            vel_gain_reg      <= RST_VEL_GAIN;
            integral_gain_reg <= RST_INTEGRAL_GAIN;
            vehicle_mass_reg  <= RST_VEHICLE_MASS;
            ascent_limit_reg  <= RST_ASCENT_LIMIT;
            time_step_reg     <= RST_TIME_STEP;
            lim_ok_reg        <= 1'b0;
            ei_reg            <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            pos_gain_reg      <= pos_gain_next;
            vel_gain_reg      <= vel_gain_next;
            integral_gain_reg <= integral_gain_next;
            vehicle_mass_reg  <= vehicle_mass_next;
            ascent_limit_reg  <= ascent_limit_next;
            time_step_reg     <= time_step_next;
            lim_ok_reg        <= lim_ok_next;
            ei_reg            <= ei_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lim_reg      <= lim_next;
        ep_reg       <= ep_next;
        ev_reg       <= ev_next;
        ff_reg       <= ff_next;
        tilt_reg     <= tilt_next;
        p_reg        <= p_next;
        d_reg        <= d_next;
        num_reg      <= num_next;
        c_reg        <= c_next;
        fm_reg       <= fm_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        mul_neg_reg  <= mul_neg_next;
        acc_reg      <= acc_next;
        div_d_reg    <= div_d_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_neg_reg  <= div_neg_next;
        m_thrust_reg <= m_thrust_next;
    end

endmodule
